[hw/rtl/blca_pkg.sv]
// ----------------------------------------------------------------------------
// blca_pkg: shared definitions for the binary lifting LCA block
// Sizes, command codes and the layout of one node's row in the tree memory.
// ----------------------------------------------------------------------------
package blca_pkg;

	// Tree size. Node fields are FIELD_W bits wide, so NODES stays at or below
	// 2**FIELD_W.
	localparam int NODES   = 1024;
	localparam int LEVELS  = 10;
	localparam int FIELD_W = 10;

	localparam int NODE_W  = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int LVL_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int DEPTH_W = FIELD_W;

	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_BUILD = 2'd1,
		CMD_QUERY = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	typedef logic [NODE_W-1:0] node_t;

	// One memory row per node: its depth and its 2^k ancestors.
	typedef struct packed {
		logic [DEPTH_W-1:0]           depth;
		logic [LEVELS-1:0][NODE_W-1:0] anc;
	} row_t;

endpackage

[hw/rtl/binary_lifting_lca.sv]
// ----------------------------------------------------------------------------
// binary_lifting_lca: lowest common ancestor by binary lifting
// Holds a rooted tree in a row-per-node memory (depth plus all ancestor
// levels) and answers LCA queries with a small sequencer.
// ----------------------------------------------------------------------------
// Throughput: one transaction at a time; busy is high while it runs.
//   load  : busy during a read-modify-write of the node's row.
//   build : busy over levels 1 to LEVELS-1 and nodes 1 to NODES-1, two memory reads per entry.
//   query : done once the lifting steps end; each step waits on at most one
//           dependent memory read.
// Reset: a clearing pass zeroes all NODES rows, one per cycle, busy high.
module binary_lifting_lca import blca_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         command,
	input  logic [FIELD_W-1:0] node_a,
	input  logic [FIELD_W-1:0] node_b,
	input  logic [FIELD_W-1:0] node_depth,
	output logic               done,
	output logic [FIELD_W-1:0] ancestor
);

	typedef enum logic [3:0] {
		S_CLR,     // clearing pass after reset
		S_IDLE,
		S_LD_RD,   // load: fetch the node's row
		S_LD_WR,   // load: write back with new parent and depth
		S_B_RDJ,   // build: fetch row j
		S_B_RDP,   // build: fetch row of anc[k-1][j]
		S_B_WR,    // build: write anc[k][j], fetch next row j
		S_Q_RD,    // query: fetch both rows
		S_Q_LD,    // query: order by depth
		S_P1_RD,   // first pass: fetch candidate ancestor of x
		S_P1_CMP,  // first pass: take it if not above y
		S_CHK,     // x == y after equalising depths
		S_P2,      // second pass: compare ancestors at level k
		S_P2_LD,   // second pass: take the new rows
		S_FIN
	} state_t;

	state_t             state_q;
	logic [NODE_W-1:0]  clr_q;
	logic [NODE_W-1:0]  j_q;
	logic [LVL_W-1:0]   k_q;
	logic [LVL_W-1:0]   km1;
	node_t              a_q, b_q, x_q, y_q, up_q;
	logic [DEPTH_W-1:0] d_q, dy_q;
	row_t               rx_q, ry_q;
	logic               done_q;
	logic [FIELD_W-1:0] anc_q;

	// Tree memory: one write port, two registered read ports.
	row_t               row_mem [NODES];
	row_t               rd_a_q, rd_b_q;
	logic               we, re_a, re_b;
	node_t              waddr, addr_a, addr_b;
	row_t               wdata;

	logic               a_ok, b_ok;
	node_t              ux, uy;

	assign km1  = k_q - LVL_W'(1);
	assign a_ok = (32'(node_a) < NODES);
	assign b_ok = (32'(node_b) < NODES);
	assign ux   = rx_q.anc[k_q];
	assign uy   = ry_q.anc[k_q];

	assign busy     = (state_q != S_IDLE);
	assign done     = done_q;
	assign ancestor = anc_q;

	// Memory port control.
	always_comb begin
		we     = 1'b0;
		waddr  = j_q;
		wdata  = rd_a_q;
		re_a   = 1'b0;
		addr_a = j_q;
		re_b   = 1'b0;
		addr_b = rx_q.anc[k_q];
		unique case (state_q)
			S_CLR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = '0;
			end
			S_LD_RD: begin
				re_a   = 1'b1;
				addr_a = a_q;
			end
			S_LD_WR: begin
				we           = 1'b1;
				waddr        = a_q;
				wdata.anc[0] = b_q;
				wdata.depth  = d_q;
			end
			S_B_RDJ: begin
				re_a = 1'b1;
			end
			S_B_RDP: begin
				re_b   = 1'b1;
				addr_b = rd_a_q.anc[km1];
			end
			S_B_WR: begin
				we             = 1'b1;
				wdata.anc[k_q] = rd_b_q.anc[km1];
				// prefetch the next row; unused after the last node
				re_a           = 1'b1;
				addr_a         = j_q + NODE_W'(1);
			end
			S_Q_RD: begin
				re_a   = 1'b1;
				addr_a = a_q;
				re_b   = 1'b1;
				addr_b = b_q;
			end
			S_P1_RD: begin
				re_b = 1'b1;
			end
			S_P2: begin
				re_a   = (ux != uy);
				addr_a = ux;
				re_b   = (ux != uy);
				addr_b = uy;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			row_mem[waddr] <= wdata;
		end
		if (re_a) begin
			rd_a_q <= row_mem[addr_a];
		end
		if (re_b) begin
			rd_b_q <= row_mem[addr_b];
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q   <= '0;
			j_q     <= '0;
			k_q     <= '0;
			a_q     <= '0;
			b_q     <= '0;
			d_q     <= '0;
			x_q     <= '0;
			y_q     <= '0;
			up_q    <= '0;
			dy_q    <= '0;
			rx_q    <= '0;
			ry_q    <= '0;
			done_q  <= 1'b0;
			anc_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + NODE_W'(1);
					if (32'(clr_q) == NODES - 1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						a_q <= NODE_W'(node_a);
						b_q <= b_ok ? NODE_W'(node_b) : '0;
						d_q <= node_depth;
						unique case (cmd_t'(command))
							CMD_LOAD: begin
								// the sentinel and out-of-range nodes are not stored
								if (node_a != '0 && a_ok) begin
									state_q <= S_LD_RD;
								end
							end
							CMD_BUILD: begin
								if (LEVELS > 1) begin
									k_q     <= LVL_W'(1);
									j_q     <= NODE_W'(1);
									state_q <= S_B_RDJ;
								end
							end
							CMD_QUERY: begin
								if (a_ok && b_ok) begin
									state_q <= S_Q_RD;
								end else begin
									done_q <= 1'b1;
									anc_q  <= '0;
								end
							end
							CMD_NOP: begin
							end
						endcase
					end
				end
				S_LD_RD: state_q <= S_LD_WR;
				S_LD_WR: state_q <= S_IDLE;
				S_B_RDJ: state_q <= S_B_RDP;
				S_B_RDP: state_q <= S_B_WR;
				S_B_WR: begin
					if (32'(j_q) == NODES - 1) begin
						j_q <= NODE_W'(1);
						if (32'(k_q) == LEVELS - 1) begin
							state_q <= S_IDLE;
						end else begin
							k_q     <= k_q + LVL_W'(1);
							state_q <= S_B_RDJ;
						end
					end else begin
						j_q     <= j_q + NODE_W'(1);
						state_q <= S_B_RDP;
					end
				end
				S_Q_RD: state_q <= S_Q_LD;
				S_Q_LD: begin
					// x is the deeper node
					if (rd_a_q.depth < rd_b_q.depth) begin
						x_q  <= b_q;
						rx_q <= rd_b_q;
						y_q  <= a_q;
						ry_q <= rd_a_q;
						dy_q <= rd_a_q.depth;
					end else begin
						x_q  <= a_q;
						rx_q <= rd_a_q;
						y_q  <= b_q;
						ry_q <= rd_b_q;
						dy_q <= rd_b_q.depth;
					end
					k_q     <= LVL_W'(LEVELS - 1);
					state_q <= S_P1_RD;
				end
				S_P1_RD: begin
					up_q    <= rx_q.anc[k_q];
					state_q <= S_P1_CMP;
				end
				S_P1_CMP: begin
					if (rd_b_q.depth >= dy_q) begin
						x_q  <= up_q;
						rx_q <= rd_b_q;
					end
					if (k_q == '0) begin
						state_q <= S_CHK;
					end else begin
						k_q     <= km1;
						state_q <= S_P1_RD;
					end
				end
				S_CHK: begin
					if (x_q == y_q) begin
						done_q  <= 1'b1;
						anc_q   <= FIELD_W'(x_q);
						state_q <= S_IDLE;
					end else begin
						k_q     <= LVL_W'(LEVELS - 1);
						state_q <= S_P2;
					end
				end
				S_P2: begin
					if (ux != uy) begin
						state_q <= S_P2_LD;
					end else if (k_q == '0) begin
						state_q <= S_FIN;
					end else begin
						k_q <= km1;
					end
				end
				S_P2_LD: begin
					rx_q <= rd_a_q;
					ry_q <= rd_b_q;
					if (k_q == '0) begin
						state_q <= S_FIN;
					end else begin
						k_q     <= km1;
						state_q <= S_P2;
					end
				end
				S_FIN: begin
					done_q  <= 1'b1;
					anc_q   <= FIELD_W'(rx_q.anc[0]);
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[hw/rtl/blca_checker.sv]
// ----------------------------------------------------------------------------
// blca_checker: port-level checks for binary_lifting_lca
// Watches the command handshake and the result strobe.
// ----------------------------------------------------------------------------
module blca_checker import blca_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [1:0] command,
	input logic       done
);

	// a result is a single-cycle strobe
	ast_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	// a result is only shown once the block is free again
	ast_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

	// an accepted query shows busy or done in the next cycle
	ast_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && command == CMD_QUERY) |=> (busy || done))
		else $error("query transaction not started");

	// only queries produce results
	ast_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && command != CMD_QUERY) |=> !done)
		else $error("result from a non-query transaction");

endmodule

bind binary_lifting_lca blca_checker u_blca_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.command (command),
	.done    (done)
);
